// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the edge antialias filter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/eaaf_pkg.sv =====
// ----------------------------------------------------------------------------
// Edge antialias filter package
// Pixel and transaction types, register codes and filter helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package eaaf_pkg;

  localparam int CHAN_W      = 8;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int NB_NUM      = 4;
  localparam int CNT_W       = $clog2(NB_NUM + 1);
  localparam int SUM_W       = CHAN_W + $clog2(NB_NUM);

  localparam logic [CFG_W-1:0] DIM_RESET = 10'd450;
  localparam int DIM_MIN = 3;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;

  localparam int EDGE_TOP   = 255;
  localparam int EDGE_STEP  = 50;
  localparam int EDGE_FLOOR = 85;
  localparam int FILL_STEP  = 55;
  localparam int FILL_BASE  = 10;
  localparam int FILL_CEIL  = 220;

  localparam int RECIP3       = 683;
  localparam int RECIP3_SHIFT = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_alpha;
    logic              in_sof;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              out_valid;
    logic              out_eof;
  } pix_out_t;

  typedef struct packed {
    pix_t centre;
    pix_t up_nb;
    pix_t down_nb;
    pix_t left_nb;
    pix_t right_nb;
    logic emit;
    logic border;
    logic last;
  } work_t;

  function automatic logic [CHAN_W-1:0] edge_alpha(input logic [CNT_W-1:0] bg);
    int v;
    v = EDGE_TOP - EDGE_STEP * int'(bg);
    if (v < EDGE_FLOOR) v = EDGE_FLOOR;
    return CHAN_W'(v);
  endfunction

  function automatic logic [CHAN_W-1:0] fill_alpha(input logic [CNT_W-1:0] fg);
    int v;
    v = FILL_STEP * int'(fg) + FILL_BASE;
    if (v > FILL_CEIL) v = FILL_CEIL;
    return CHAN_W'(v);
  endfunction

  function automatic logic [CHAN_W-1:0] mean_chan(input logic [SUM_W-1:0] s,
                                                  input logic [CNT_W-1:0] n);
    logic [SUM_W+RECIP3_SHIFT-1:0] prod;
    logic [CHAN_W-1:0]             q;
    prod = (SUM_W + RECIP3_SHIFT)'(s) * (SUM_W + RECIP3_SHIFT)'(RECIP3);
    unique case (n)
      CNT_W'(1): q = s[CHAN_W-1:0];
      CNT_W'(2): q = s[1 +: CHAN_W];
      CNT_W'(3): q = prod[RECIP3_SHIFT +: CHAN_W];
      CNT_W'(4): q = s[2 +: CHAN_W];
      default:   q = '0;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== design/eaaf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module eaaf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

// ===== design/eaaf_front.sv =====
// ----------------------------------------------------------------------------
// Edge antialias filter front end
// Accepts pixels, tracks frame position, runs the line store and window.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module eaaf_front #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [eaaf_pkg::CFG_W-1:0]    frame_width,
  input  logic [eaaf_pkg::CFG_W-1:0]    frame_height,
  input  logic                          in_push,
  input  eaaf_pkg::pix_in_t             in_data,
  output logic                          in_full,
  input  logic [eaaf_pkg::QCNT_W-1:0]   q_count,
  output logic                          q_push,
  output eaaf_pkg::work_t               q_data
);

  import eaaf_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 2);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT);

  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_t;

  logic [WW-1:0] w, w_last;
  logic [HW-1:0] h, h_last;

  logic          in_acc;
  pix_t          pix_in;
  logic [AW-1:0] ptr_r, ptr_cur, ptr_nxt;
  logic [WW-1:0] fill_r, fill_cur, fill_nxt;
  logic [AW-1:0] col_r, col_cur, col_nxt;
  logic [RW-1:0] row_r, row_cur, row_nxt;
  logic          done_r, done_cur, done_nxt;
  logic          col_end, row_end, filling, emit, border, last;

  logic          clr_active_r, clr_active_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  logic          s1_valid_r;
  logic [AW-1:0] s1_addr_r;
  pix_t          s1_pix_r;
  logic          s1_emit_r, s1_border_r, s1_last_r;
  logic          s1_byp_r;
  line_t         s1_byp_data_r;

  line_t         rd_line, wr_line;
  logic [$bits(line_t)-1:0] ram_rd_data, ram_wr_data;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  pix_t          mid_out, up_out;

  pix_t          up_r, down_r, win0_r, win1_r, win2_r;

  always_comb begin
    if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else if (32'(frame_width) < 32'(DIM_MIN)) begin
      w = WW'(DIM_MIN);
    end else begin
      w = WW'(frame_width);
    end
    if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else if (32'(frame_height) < 32'(DIM_MIN)) begin
      h = HW'(DIM_MIN);
    end else begin
      h = HW'(frame_height);
    end
    w_last = w - WW'(1);
    h_last = h - HW'(1);
  end

  assign in_full = clr_active_r ||
                   (32'(q_count) + 32'(s1_valid_r) >= 32'(QUEUE_DEPTH));
  assign in_acc  = in_push && !in_full;

  assign pix_in = '{alpha: in_data.in_alpha, blue: in_data.in_blue,
                    green: in_data.in_green, red: in_data.in_red};

  always_comb begin
    ptr_cur  = in_data.in_sof ? '0 : ptr_r;
    fill_cur = in_data.in_sof ? '0 : fill_r;
    col_cur  = in_data.in_sof ? '0 : col_r;
    row_cur  = in_data.in_sof ? '0 : row_r;
    done_cur = in_data.in_sof ? 1'b0 : done_r;

    col_end = WW'(col_cur) >= w_last;
    row_end = HW'(row_cur) >= h_last;
    filling = fill_cur < (w + WW'(1));
    emit    = !filling && !done_cur;
    border  = (row_cur == '0) || row_end || (col_cur == '0) || col_end;
    last    = row_end && col_end;

    ptr_nxt  = ptr_r;
    fill_nxt = fill_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    done_nxt = done_r;
    if (in_acc) begin
      ptr_nxt  = (WW'(ptr_cur) + WW'(1) >= w) ? '0 : ptr_cur + AW'(1);
      fill_nxt = fill_cur;
      col_nxt  = col_cur;
      row_nxt  = row_cur;
      done_nxt = done_cur;
      if (filling) begin
        fill_nxt = fill_cur + WW'(1);
      end else if (emit) begin
        priority if (last) begin
          done_nxt = 1'b1;
        end else if (col_end) begin
          col_nxt = '0;
          row_nxt = row_cur + RW'(1);
        end else begin
          col_nxt = col_cur + AW'(1);
        end
      end
    end
  end

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      if (clr_addr_r == AW'(MAX_WIDTH - 1)) begin
        clr_active_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
    end
  end

  // Line store: read at the current pointer, write back in the next cycle.
  assign rd_line = s1_byp_r ? s1_byp_data_r : line_t'(ram_rd_data);
  assign mid_out = rd_line.middle;
  assign up_out  = rd_line.upper;
  assign wr_line = '{upper: mid_out, middle: s1_pix_r};

  assign ram_wr_en   = clr_active_r || s1_valid_r;
  assign ram_wr_addr = clr_active_r ? clr_addr_r : s1_addr_r;
  assign ram_wr_data = clr_active_r ? '0 : wr_line;

  eaaf_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ptr_cur),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r        <= '0;
      fill_r       <= '0;
      col_r        <= '0;
      row_r        <= '0;
      done_r       <= 1'b0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      up_r         <= '0;
      down_r       <= '0;
      win0_r       <= '0;
      win1_r       <= '0;
      win2_r       <= '0;
    end else begin
      ptr_r        <= ptr_nxt;
      fill_r       <= fill_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      done_r       <= done_nxt;
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      s1_valid_r   <= in_acc;
      if (s1_valid_r) begin
        up_r   <= up_out;
        down_r <= s1_pix_r;
        win0_r <= mid_out;
        win1_r <= win0_r;
        win2_r <= win1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr_r     <= ptr_cur;
      s1_pix_r      <= pix_in;
      s1_emit_r     <= emit;
      s1_border_r   <= border;
      s1_last_r     <= last;
      s1_byp_r      <= s1_valid_r && (s1_addr_r == ptr_cur);
      s1_byp_data_r <= wr_line;
    end
  end

  assign q_push = s1_valid_r;
  assign q_data = '{centre: win0_r, up_nb: up_r, down_nb: down_r, left_nb: win1_r,
                    right_nb: mid_out, emit: s1_emit_r, border: s1_border_r,
                    last: s1_last_r};

  `ASSERT_PROP(a_done_after_last, clk, rst_n, in_acc && emit && last |=> done_r, "no frame close")
  `ASSERT_NEVER(a_no_acc_in_clear, clk, rst_n, in_acc && clr_active_r, "accept during clear")

endmodule

`default_nettype wire

// ===== design/eaaf_queue.sv =====
// ----------------------------------------------------------------------------
// Edge antialias filter work queue
// Short queue between the front end and the filter back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module eaaf_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  eaaf_pkg::work_t             push_data,
  input  logic                        pop,
  output eaaf_pkg::work_t             pop_data,
  output logic                        empty,
  output logic [eaaf_pkg::QCNT_W-1:0] count
);

  import eaaf_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  work_t             slot_r [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign count_nxt = count_r + QCNT_W'(push) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = slot_r[rd_ptr_r];
  assign empty    = count_r == '0;
  assign count    = count_r;

  `ASSERT_NEVER(a_q_overflow, clk, rst_n, push && !pop && count_r == FULL_CNT, "queue overflow")
  `ASSERT_NEVER(a_q_underflow, clk, rst_n, pop && (count_r == '0), "queue underflow")

endmodule

`default_nettype wire

// ===== design/eaaf_back.sv =====
// ----------------------------------------------------------------------------
// Edge antialias filter back end
// Applies the four-neighbour stencil and holds the result for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module eaaf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  eaaf_pkg::work_t    q_data,
  output logic               q_pop,
  output eaaf_pkg::pix_out_t out_data,
  output logic               out_empty,
  input  logic               out_pop
);

  import eaaf_pkg::*;

  pix_t             nb [NB_NUM];
  pix_t             centre, res_pix;
  logic [CNT_W-1:0] bg, fg;
  logic [SUM_W-1:0] sum_red, sum_green, sum_blue;
  pix_out_t         res_nxt, res_r;
  logic             res_valid_r, take;

  assign take  = !q_empty && (!res_valid_r || out_pop);
  assign q_pop = take;

  always_comb begin
    centre = q_data.centre;
    nb[0]  = q_data.up_nb;
    nb[1]  = q_data.down_nb;
    nb[2]  = q_data.left_nb;
    nb[3]  = q_data.right_nb;
    bg        = '0;
    fg        = '0;
    sum_red   = '0;
    sum_green = '0;
    sum_blue  = '0;
    for (int i = 0; i < NB_NUM; i++) begin
      if (nb[i].alpha == ALPHA_CLEAR) begin
        bg = bg + CNT_W'(1);
      end
      if (nb[i].alpha == ALPHA_OPAQUE) begin
        fg        = fg + CNT_W'(1);
        sum_red   = sum_red + SUM_W'(nb[i].red);
        sum_green = sum_green + SUM_W'(nb[i].green);
        sum_blue  = sum_blue + SUM_W'(nb[i].blue);
      end
    end

    res_pix = centre;
    if (!q_data.border) begin
      if (centre.alpha == ALPHA_OPAQUE && bg != '0) begin
        res_pix.alpha = edge_alpha(bg);
      end else if (centre.alpha == ALPHA_CLEAR && fg != '0) begin
        res_pix.red   = mean_chan(sum_red, fg);
        res_pix.green = mean_chan(sum_green, fg);
        res_pix.blue  = mean_chan(sum_blue, fg);
        res_pix.alpha = fill_alpha(fg);
      end
    end

    res_nxt = '0;
    if (q_data.emit) begin
      res_nxt.out_red   = res_pix.red;
      res_nxt.out_green = res_pix.green;
      res_nxt.out_blue  = res_pix.blue;
      res_nxt.out_alpha = res_pix.alpha;
      res_nxt.out_valid = 1'b1;
      res_nxt.out_eof   = q_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (take) begin
      res_valid_r <= 1'b1;
    end else if (out_pop) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_data  = res_r;
  assign out_empty = !res_valid_r;

endmodule

`default_nettype wire

// ===== design/edge_alpha_antialias_filter.sv =====
// Path: an input transaction is registered in stage 1, queued, then registered as the result.
// Throughput: one transaction per cycle while in_full is low, set by the line store read then write-back.
// The filtered pixel of a position leaves frame_width + 1 transactions after it entered.
// Reset: rst_n synchronous, active low; registers return to 450 x 450.
// After reset all MAX_WIDTH line store entries are swept to zero, in_full held high.
// ----------------------------------------------------------------------------
// Edge alpha antialias filter
// Streaming four-neighbour alpha edge softening over RGBA raster frames.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_alpha_antialias_filter #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [eaaf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eaaf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_push,
  input  eaaf_pkg::pix_in_t              in_data,
  output logic                           in_full,
  output eaaf_pkg::pix_out_t             out_data,
  output logic                           out_empty,
  input  logic                           out_pop
);

  import eaaf_pkg::*;

  logic [CFG_W-1:0]  frame_width_r, frame_height_r;
  logic              q_push, q_pop, q_empty;
  logic [QCNT_W-1:0] q_count;
  work_t             q_wr_data, q_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DIM_RESET;
      frame_height_r <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  eaaf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .in_push      (in_push),
    .in_data      (in_data),
    .in_full      (in_full),
    .q_count      (q_count),
    .q_push       (q_push),
    .q_data       (q_wr_data)
  );

  eaaf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_data),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .empty     (q_empty),
    .count     (q_count)
  );

  eaaf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_data  (out_data),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

`default_nettype wire
